// File: hdl/pfmt_pkg.sv
// ----------------------------------------------------------------------------
// pfmt_pkg
// Types and constants shared by the flow meter totalizer core, its serial
// rate unit and its port checker.
// ----------------------------------------------------------------------------
package pfmt_pkg;

  localparam int PULSE_W    = 24;
  localparam int ML_W       = 24;
  localparam int TIMER_W    = 16;
  localparam int SINCE_W    = 32;
  localparam int VOL_W      = 48;
  localparam int RATE_W     = 40;
  localparam int PROD_W     = 58;   // window volume times the rate scale
  localparam int STEP_W     = 6;    // counts up to PROD_W - 1
  localparam int SCALE_W    = 10;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;

  localparam logic [SCALE_W-1:0] RATE_SCALE = 10'd1000;   // ticks per second

  localparam logic [ML_W-1:0]    ML_RESET     = 24'd145635;
  localparam logic [VOL_W-1:0]   TANK_RESET   = 48'd327680000;
  localparam logic [TIMER_W-1:0] WINDOW_RESET = 16'd500;
  localparam logic [TIMER_W-1:0] DECAY_RESET  = 16'd1000;
  localparam logic [SINCE_W-1:0] STOP_RESET   = 32'd3000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ML_PER_PULSE    = 3'd0,
    REG_TANK_CAPACITY   = 3'd1,
    REG_WINDOW_MS       = 3'd2,
    REG_DECAY_MS        = 3'd3,
    REG_STOP_TIMEOUT_MS = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [1:0] pulse_edges;
    logic       clear_volume;
  } in_t;

  typedef struct packed {
    logic [VOL_W-1:0]  volume_total;
    logic [VOL_W-1:0]  volume_remaining;
    logic [RATE_W-1:0] flow_rate;
    logic              flow_stopped;
    logic              window_done;
  } out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_FINISH
  } top_state_t;

  typedef enum logic [1:0] {
    U_IDLE,
    U_MUL,
    U_LOAD,
    U_DIV
  } unit_state_t;

  typedef struct packed {
    logic delta_valid;   // window volume shown on delta this cycle
    logic done;          // rate shown on rate, one cycle
  } unit_status_t;

endpackage

// File: hdl/pfmt_rate_unit.sv
// ----------------------------------------------------------------------------
// pfmt_rate_unit
// Serial window arithmetic: pulses times mL-per-pulse by shift-add, one
// multiplier bit a cycle, then times 1000 the same way, then a restoring
// divide by the window length, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module pfmt_rate_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [pfmt_pkg::PULSE_W-1:0]   pulses,
  input  logic [pfmt_pkg::ML_W-1:0]      ml,
  input  logic [pfmt_pkg::TIMER_W-1:0]   len,
  output logic [pfmt_pkg::VOL_W-1:0]     delta,
  output logic [pfmt_pkg::RATE_W-1:0]    rate,
  output pfmt_pkg::unit_status_t         status
);
  import pfmt_pkg::*;

  unit_state_t         state, state_next;
  logic [PROD_W-1:0]   acc;
  logic [PROD_W-1:0]   mcand;      // multiplicand, then quotient
  logic [PULSE_W-1:0]  mplier;
  logic [STEP_W-1:0]   cnt;
  logic                scale_pass;
  logic [TIMER_W-1:0]  rem;
  logic                done;

  logic                last_mul, last_div, fits;
  logic [TIMER_W:0]    trial, diff;
  logic [PROD_W-1:0]   q_next;

  assign last_mul = scale_pass ? (cnt == STEP_W'(SCALE_W - 1))
                               : (cnt == STEP_W'(PULSE_W - 1));
  assign last_div = (cnt == STEP_W'(PROD_W - 1));
  assign trial    = {rem, acc[PROD_W-1]};
  assign diff     = trial - {1'b0, len};
  assign fits     = (trial >= {1'b0, len});
  assign q_next   = {mcand[PROD_W-2:0], fits};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= U_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      U_IDLE: begin
        if (start) state_next = U_MUL;
      end
      U_MUL: begin
        if (last_mul) state_next = scale_pass ? U_DIV : U_LOAD;
      end
      U_LOAD: begin
        state_next = U_MUL;
      end
      U_DIV: begin
        if (last_div) state_next = U_IDLE;
      end
      default: state_next = U_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (state == U_DIV) && last_div;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      U_IDLE: begin
        if (start) begin
          acc        <= '0;
          mcand      <= PROD_W'(ml);
          mplier     <= pulses;
          cnt        <= '0;
          scale_pass <= 1'b0;
        end
      end
      U_MUL: begin
        if (mplier[0]) acc <= acc + mcand;
        mcand  <= {mcand[PROD_W-2:0], 1'b0};
        mplier <= {1'b0, mplier[PULSE_W-1:1]};
        cnt    <= last_mul ? '0 : cnt + STEP_W'(1);
        rem    <= '0;
      end
      U_LOAD: begin
        // acc holds the window volume, scale it by the tick rate next
        mcand      <= acc;
        mplier     <= PULSE_W'(RATE_SCALE);
        acc        <= '0;
        cnt        <= '0;
        scale_pass <= 1'b1;
      end
      U_DIV: begin
        rem   <= fits ? diff[TIMER_W-1:0] : trial[TIMER_W-1:0];
        acc   <= {acc[PROD_W-2:0], 1'b0};
        mcand <= q_next;
        cnt   <= cnt + STEP_W'(1);
        if (last_div) begin
          rate <= (|q_next[PROD_W-1:RATE_W]) ? '1 : q_next[RATE_W-1:0];
        end
      end
      default: ;
    endcase
  end

  assign delta              = acc[VOL_W-1:0];
  assign status.delta_valid = (state == U_LOAD);
  assign status.done        = done;

endmodule

// File: hdl/pulse_flow_meter_totalizer_core.sv
// ----------------------------------------------------------------------------
// pulse_flow_meter_totalizer_core
// Millisecond tick totalizer: counts sensor pulses per window, keeps total
// and remaining volume, window flow rate and a flow-stopped flag.
//
//   channel   dir  handshake              word
//   in        in   in_valid / in_ready    in_t  (pulse_edges, clear_volume)
//   out       out  out_valid / out_ready  out_t (volumes, rate, flags)
//   cfg       in   cfg_we                 cfg_index, cfg_data
//
// a tick that ends no window, or ends one without pulses, goes straight to
// the finish state; a tick that ends a window with pulses first runs 24
// multiply steps, a reload, 10 scale steps and 58 divide steps in the serial
// rate unit, then hands the word over
// one word is in flight at a time; out holds its word until taken
// reset loads the default registers and the default tank capacity
// ----------------------------------------------------------------------------
module pulse_flow_meter_totalizer_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  pfmt_pkg::in_t                     in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output pfmt_pkg::out_t                    out_data,
  input  logic                              cfg_we,
  input  logic [pfmt_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pfmt_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import pfmt_pkg::*;

  top_state_t          state, state_next;

  logic [ML_W-1:0]     ml_per_pulse;
  logic [TIMER_W-1:0]  window_ms;
  logic [TIMER_W-1:0]  decay_ms;
  logic [SINCE_W-1:0]  stop_timeout_ms;

  logic [PULSE_W-1:0]  window_pulses;
  logic [TIMER_W-1:0]  window_timer;
  logic [SINCE_W-1:0]  since_flow_timer;
  logic [VOL_W-1:0]    total_volume;
  logic [VOL_W-1:0]    remaining_volume;
  logic [RATE_W-1:0]   rate_value;
  logic                done_flag;

  logic                in_accept, can_load, window_hit, calc_start;
  logic [TIMER_W-1:0]  len;
  logic [PULSE_W:0]    pulses_sum;
  logic [PULSE_W-1:0]  pulses_sat;
  logic [TIMER_W-1:0]  timer_inc;
  logic [SINCE_W-1:0]  since_inc;
  logic [VOL_W:0]      total_sum;

  logic [VOL_W-1:0]    delta;
  logic [RATE_W-1:0]   unit_rate;
  unit_status_t        unit_status;

  assign in_ready   = (state == ST_IDLE);
  assign in_accept  = in_valid && in_ready;
  assign can_load   = !out_valid || out_ready;

  assign len        = (window_ms == '0) ? TIMER_W'(1) : window_ms;
  assign pulses_sum = {1'b0, window_pulses} + (PULSE_W + 1)'(in_data.pulse_edges);
  assign pulses_sat = pulses_sum[PULSE_W] ? '1 : pulses_sum[PULSE_W-1:0];
  assign timer_inc  = (&window_timer) ? window_timer : window_timer + TIMER_W'(1);
  assign since_inc  = (&since_flow_timer) ? since_flow_timer
                                          : since_flow_timer + SINCE_W'(1);
  assign window_hit = (timer_inc >= len);
  assign calc_start = in_accept && !in_data.clear_volume && window_hit
                      && (pulses_sat != '0);
  assign total_sum  = {1'b0, total_volume} + {1'b0, delta};

  pfmt_rate_unit u_rate (
    .clk    (clk),
    .rst    (rst),
    .start  (calc_start),
    .pulses (pulses_sat),
    .ml     (ml_per_pulse),
    .len    (len),
    .delta  (delta),
    .rate   (unit_rate),
    .status (unit_status)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_accept) state_next = calc_start ? ST_CALC : ST_FINISH;
      end
      ST_CALC: begin
        if (unit_status.done) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (can_load) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ml_per_pulse     <= ML_RESET;
      window_ms        <= WINDOW_RESET;
      decay_ms         <= DECAY_RESET;
      stop_timeout_ms  <= STOP_RESET;
      window_pulses    <= '0;
      window_timer     <= '0;
      since_flow_timer <= '0;
      total_volume     <= '0;
      remaining_volume <= TANK_RESET;
      rate_value       <= '0;
      done_flag        <= 1'b0;
    end else begin
      if (in_accept) begin
        if (in_data.clear_volume) begin
          window_pulses    <= '0;
          window_timer     <= '0;
          since_flow_timer <= '0;
          total_volume     <= '0;
          rate_value       <= '0;
          done_flag        <= 1'b0;
        end else if (window_hit) begin
          window_pulses <= '0;
          window_timer  <= '0;
          done_flag     <= 1'b1;
          if (pulses_sat != '0) begin
            since_flow_timer <= '0;
          end else begin
            since_flow_timer <= since_inc;
            // idle window: rate decays once flow has been gone long enough
            if (since_inc > SINCE_W'(decay_ms)) rate_value <= '0;
          end
        end else begin
          window_pulses    <= pulses_sat;
          window_timer     <= timer_inc;
          since_flow_timer <= since_inc;
          done_flag        <= 1'b0;
        end
      end

      if (unit_status.delta_valid) begin
        total_volume     <= total_sum[VOL_W] ? '1 : total_sum[VOL_W-1:0];
        remaining_volume <= (remaining_volume > delta) ? remaining_volume - delta : '0;
      end
      if (unit_status.done) rate_value <= unit_rate;

      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_ML_PER_PULSE:    ml_per_pulse     <= cfg_data[ML_W-1:0];
          REG_TANK_CAPACITY:   remaining_volume <= cfg_data[VOL_W-1:0];
          REG_WINDOW_MS:       window_ms        <= cfg_data[TIMER_W-1:0];
          REG_DECAY_MS:        decay_ms         <= cfg_data[TIMER_W-1:0];
          REG_STOP_TIMEOUT_MS: stop_timeout_ms  <= cfg_data[SINCE_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == ST_FINISH) && can_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_FINISH) && can_load) begin
      out_data.volume_total     <= total_volume;
      out_data.volume_remaining <= remaining_volume;
      out_data.flow_rate        <= rate_value;
      out_data.flow_stopped     <= (since_flow_timer > stop_timeout_ms);
      out_data.window_done      <= done_flag;
    end
  end

endmodule

// File: hdl/pfmt_checker.sv
// ----------------------------------------------------------------------------
// pfmt_port_props
// Port-level checks on the totalizer core, attached by bind.
// ----------------------------------------------------------------------------
module pfmt_port_props (
  input logic            clk,
  input logic            rst,
  input logic            in_valid,
  input logic            in_ready,
  input logic            out_valid,
  input logic            out_ready,
  input pfmt_pkg::out_t  out_data
);
  import pfmt_pkg::*;

  // a waiting result word holds still
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  // one word in flight: the input is closed in the cycle after an accepted tick
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again right after accept");

  // a new result only appears from the busy state
  a_result_from_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result raised while input side was idle");

  // reset leaves an empty output and an open input
  a_reset_state: assert property (@(posedge clk)
    rst |=> in_ready && !out_valid)
    else $error("bad state after reset");

endmodule

bind pulse_flow_meter_totalizer_core pfmt_port_props u_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
